@@ design/utf8v_pkg.sv @@
// utf8v_pkg: shared types and byte constants for the utf-8 stream validator
// no dependencies
`timescale 1ns / 1ps

package utf8v_pkg;

  // limit on the byte that follows certain lead bytes
  typedef enum logic [2:0] {
    RULE_NONE   = 3'd0,
    RULE_MIN_A0 = 3'd1,
    RULE_MAX_9F = 3'd2,
    RULE_MIN_90 = 3'd3,
    RULE_MAX_8F = 3'd4
  } rule_t;

  localparam logic [7:0] CONT_MASK   = 8'hC0;
  localparam logic [7:0] CONT_MARK   = 8'h80;
  localparam logic [7:0] ASCII_TOP   = 8'h80;
  localparam logic [7:0] CTRL_TOP    = 8'h20;
  localparam logic [7:0] BYTE_TAB    = 8'h09;
  localparam logic [7:0] BYTE_LF     = 8'h0A;
  localparam logic [7:0] BYTE_CR     = 8'h0D;
  localparam logic [7:0] LEAD2_LO    = 8'hC2;
  localparam logic [7:0] LEAD2_HI    = 8'hDF;
  localparam logic [7:0] LEAD3_LO    = 8'hE0;
  localparam logic [7:0] LEAD3_HI    = 8'hEF;
  localparam logic [7:0] LEAD3_SURR  = 8'hED;
  localparam logic [7:0] LEAD4_LO    = 8'hF0;
  localparam logic [7:0] LEAD4_HI    = 8'hF4;
  localparam logic [7:0] LIMIT_A0    = 8'hA0;
  localparam logic [7:0] LIMIT_90    = 8'h90;

endpackage

@@ design/utf8_stream_validator.sv @@
// utf8_stream_validator: strict utf-8 check of a byte stream, one verdict per string
// depends on utf8v_pkg
`timescale 1ns / 1ps

// Usage
//   Input channel: in_valid / in_stall carry one beat per string byte, text_byte
//   with final_byte high on the last byte of the string. Output channel:
//   out_valid / out_stall carry one beat per string, string_valid high when the
//   whole string was well-formed utf-8 with no bytes below 0x20 other than tab,
//   LF and CR. Bytes that are not last produce no output beat.
//   Throughput: one byte per cycle while in_stall is low; the per-byte decision
//   is a single level of compare logic feeding the parser state registers.
//   The verdict appears in the output register in the cycle after the last
//   byte is accepted.
//   When the receiver stalls with a verdict waiting, in_stall goes high until
//   that verdict is taken; the waiting verdict is held unchanged.
//   Reset (rst, synchronous) clears the parser state and drops out_valid; the
//   block accepts bytes in the first cycle after reset.
//   An error is sticky until the last byte, after which the state clears.

module utf8_stream_validator
  import utf8v_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] text_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       string_valid
);

  logic [1:0] bytes_still_expected, bytes_still_expected_next;
  rule_t      second_byte_rule, second_byte_rule_next;
  logic       error_seen, error_seen_next;
  logic       out_valid_next;
  logic       accept;
  logic       second_ok;
  logic       verdict;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    case (second_byte_rule)
      RULE_MIN_A0: second_ok = (text_byte >= LIMIT_A0);
      RULE_MAX_9F: second_ok = (text_byte <  LIMIT_A0);
      RULE_MIN_90: second_ok = (text_byte >= LIMIT_90);
      RULE_MAX_8F: second_ok = (text_byte <  LIMIT_90);
      default:     second_ok = 1'b1;
    endcase
  end

  always_comb begin
    bytes_still_expected_next = bytes_still_expected;
    second_byte_rule_next     = second_byte_rule;
    error_seen_next           = error_seen;
    if (bytes_still_expected != 2'd0) begin
      // a bad continuation still uses up its slot
      if (((text_byte & CONT_MASK) != CONT_MARK) || !second_ok)
        error_seen_next = 1'b1;
      bytes_still_expected_next = bytes_still_expected - 2'd1;
      second_byte_rule_next     = RULE_NONE;
    end else if (text_byte < ASCII_TOP) begin
      if (text_byte < CTRL_TOP && text_byte != BYTE_TAB &&
          text_byte != BYTE_LF && text_byte != BYTE_CR)
        error_seen_next = 1'b1;
    end else if (text_byte >= LEAD2_LO && text_byte <= LEAD2_HI) begin
      bytes_still_expected_next = 2'd1;
      second_byte_rule_next     = RULE_NONE;
    end else if (text_byte >= LEAD3_LO && text_byte <= LEAD3_HI) begin
      bytes_still_expected_next = 2'd2;
      if (text_byte == LEAD3_LO)
        second_byte_rule_next = RULE_MIN_A0;
      else if (text_byte == LEAD3_SURR)
        second_byte_rule_next = RULE_MAX_9F;
      else
        second_byte_rule_next = RULE_NONE;
    end else if (text_byte >= LEAD4_LO && text_byte <= LEAD4_HI) begin
      bytes_still_expected_next = 2'd3;
      if (text_byte == LEAD4_LO)
        second_byte_rule_next = RULE_MIN_90;
      else if (text_byte == LEAD4_HI)
        second_byte_rule_next = RULE_MAX_8F;
      else
        second_byte_rule_next = RULE_NONE;
    end else begin
      error_seen_next = 1'b1;
    end
  end

  // cut-short sequences fail here too
  assign verdict = !error_seen_next && (bytes_still_expected_next == 2'd0);

  always_comb begin
    if (accept && final_byte)
      out_valid_next = 1'b1;
    else if (out_stall)
      out_valid_next = out_valid;
    else
      out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_still_expected <= 2'd0;
      second_byte_rule     <= RULE_NONE;
      error_seen           <= 1'b0;
      out_valid            <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (accept) begin
        if (final_byte) begin
          bytes_still_expected <= 2'd0;
          second_byte_rule     <= RULE_NONE;
          error_seen           <= 1'b0;
        end else begin
          bytes_still_expected <= bytes_still_expected_next;
          second_byte_rule     <= second_byte_rule_next;
          error_seen           <= error_seen_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && final_byte)
      string_valid <= verdict;
  end

`ifndef NO_ASSERTIONS
  // the last beat of a string always leaves a clean parser behind
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && final_byte |=> bytes_still_expected == 2'd0 && !error_seen &&
                             second_byte_rule == RULE_NONE)
    else $error("parser state not cleared after last byte");

  // three-byte limits only with two bytes due, four-byte limits only with three
  a_rule_three: assert property (@(posedge clk) disable iff (rst)
    (second_byte_rule == RULE_MIN_A0 || second_byte_rule == RULE_MAX_9F)
      |-> bytes_still_expected == 2'd2)
    else $error("three-byte limit without two bytes due");

  a_rule_four: assert property (@(posedge clk) disable iff (rst)
    (second_byte_rule == RULE_MIN_90 || second_byte_rule == RULE_MAX_8F)
      |-> bytes_still_expected == 2'd3)
    else $error("four-byte limit without three bytes due");

  // every accepted last byte yields a verdict beat in the next cycle
  a_verdict_follows: assert property (@(posedge clk) disable iff (rst)
    accept && final_byte |=> out_valid)
    else $error("verdict missing after last byte");

  // a string with an error already seen can never pass
  a_sticky_error: assert property (@(posedge clk) disable iff (rst)
    accept && final_byte && error_seen |=> !string_valid)
    else $error("string with earlier error reported valid");
`endif

endmodule
